@@ src/wzh_pkg.sv @@
// ----------------------------------------------------------------------------
// wzh_pkg
// shared types and codes for the window stacking order hit test
// ----------------------------------------------------------------------------
package wzh_pkg;

	localparam logic [1:0] OP_REG   = 2'd0;
	localparam logic [1:0] OP_HIT   = 2'd1;
	localparam logic [1:0] OP_RAISE = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_UNREG = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic signed [10:0] left;
		logic signed [10:0] top;
		logic [9:0]         width;
		logic [9:0]         height;
	} rect_t;

endpackage

@@ src/window_zorder_hit_test.sv @@
// ----------------------------------------------------------------------------
// window_zorder_hit_test
// window table with stacking order: register, hit-test, bring to top
// ----------------------------------------------------------------------------
// channel   ports                                       handshake
// request   operation pos_x pos_y width height slot     start & !busy
// result    status slot_out window_count                done, one cycle
//
// register and error cases raise done straight from the dispatch state.
// hit-test walks the stack top-down through a read pipeline
// (stack memory, rectangle memory, containment unit).
// bring-to-top searches then shifts the stack memory one entry a cycle
// over its single write port.
// reset empties the table at once; the receiver cannot stall results.
module window_zorder_hit_test #(
	parameter int MAX_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [10:0] pos_x,
	input  logic signed [10:0] pos_y,
	input  logic [9:0]         width,
	input  logic [9:0]         height,
	input  logic [2:0]         slot,
	output logic               done,
	output logic [1:0]         status,
	output logic [2:0]         slot_out,
	output logic [3:0]         window_count
);
	import wzh_pkg::*;

	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_HIT   = 3'd2;
	localparam logic [2:0] S_FIND  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_TOP   = 3'd5;

	logic [2:0]         state_q;
	logic [CW-1:0]      used_q;
	logic [SW-1:0]      idx_q;
	logic               iss_q;
	logic               v1_s1;
	logic [SW-1:0]      tag_s1;
	logic               v2_s2;
	logic [SW-1:0]      slot_s2;
	logic               done_q;
	logic [1:0]         status_q;
	logic [2:0]         slot_out_q;

	logic [1:0]         op_q;
	logic signed [10:0] px_q;
	logic signed [10:0] py_q;
	logic [9:0]         w_q;
	logic [9:0]         h_q;
	logic [2:0]         sel_q;

	logic               accept;
	logic               issue;
	logic [SW-1:0]      last_idx;
	logic [SW-1:0]      sel_idx;
	logic               is_full;
	logic               sel_unreg;
	logic               hit;

	logic               rect_we;
	rect_t              rect_wdata;
	rect_t              rect_rdata;
	logic               stack_we;
	logic [SW-1:0]      stack_waddr;
	logic [SW-1:0]      stack_wdata;
	logic [SW-1:0]      stack_rdata;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign last_idx  = SW'(used_q - CW'(1));
	assign sel_idx   = SW'(sel_q);
	assign is_full   = (used_q >= CW'(MAX_SLOTS));
	assign sel_unreg = ((CW + 3)'(sel_q) >= (CW + 3)'(used_q));
	assign issue     = iss_q && ((state_q == S_HIT) || (state_q == S_FIND) ||
		(state_q == S_SHIFT));

	assign rect_we    = (state_q == S_DISP) && (op_q == OP_REG) && !is_full;
	assign rect_wdata = '{left: px_q, top: py_q, width: w_q, height: h_q};

	always_comb begin
		stack_we    = 1'b0;
		stack_waddr = SW'(used_q);
		stack_wdata = SW'(used_q);
		case (state_q)
			S_DISP: begin
				stack_we = (op_q == OP_REG) && !is_full;
			end
			S_SHIFT: begin
				stack_we    = v1_s1;
				stack_waddr = tag_s1 - SW'(1);
				stack_wdata = stack_rdata;
			end
			S_TOP: begin
				stack_we    = 1'b1;
				stack_waddr = last_idx;
				stack_wdata = sel_idx;
			end
			default: begin
				stack_we = 1'b0;
			end
		endcase
	end

	wzh_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
		.clk         (clk),
		.rect_we     (rect_we),
		.rect_waddr  (SW'(used_q)),
		.rect_wdata  (rect_wdata),
		.rect_raddr  (stack_rdata),
		.rect_rdata  (rect_rdata),
		.stack_we    (stack_we),
		.stack_waddr (stack_waddr),
		.stack_wdata (stack_wdata),
		.stack_raddr (idx_q),
		.stack_rdata (stack_rdata)
	);

	wzh_hit_unit u_hit (
		.px   (px_q),
		.py   (py_q),
		.rect (rect_rdata),
		.hit  (hit)
	);

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= operation;
			px_q  <= pos_x;
			py_q  <= pos_y;
			w_q   <= width;
			h_q   <= height;
			sel_q <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			idx_q      <= '0;
			iss_q      <= 1'b0;
			v1_s1      <= 1'b0;
			tag_s1     <= '0;
			v2_s2      <= 1'b0;
			slot_s2    <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			slot_out_q <= '0;
		end else begin
			v1_s1   <= issue;
			tag_s1  <= idx_q;
			v2_s2   <= v1_s1;
			slot_s2 <= stack_rdata;
			done_q  <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					iss_q      <= 1'b0;
					status_q   <= ST_OK;
					slot_out_q <= '0;
					case (op_q)
						OP_REG: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (is_full) begin
								status_q <= ST_FULL;
							end else begin
								slot_out_q <= 3'(used_q);
								used_q     <= used_q + CW'(1);
							end
						end
						OP_HIT: begin
							if (used_q == '0) begin
								status_q <= ST_MISS;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								idx_q   <= last_idx;
								iss_q   <= 1'b1;
								state_q <= S_HIT;
							end
						end
						OP_RAISE: begin
							if (sel_unreg) begin
								status_q <= ST_UNREG;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								idx_q   <= '0;
								iss_q   <= 1'b1;
								state_q <= S_FIND;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_HIT: begin
					if (iss_q) begin
						if (idx_q == '0) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q - SW'(1);
						end
					end
					if (v2_s2 && hit) begin
						status_q   <= ST_OK;
						slot_out_q <= 3'(slot_s2);
						done_q     <= 1'b1;
						iss_q      <= 1'b0;
						state_q    <= S_IDLE;
					end else if (v2_s2 && !v1_s1) begin
						status_q <= ST_MISS;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_FIND: begin
					idx_q <= idx_q + SW'(1);
					if (v1_s1 && (stack_rdata == sel_idx)) begin
						v1_s1 <= 1'b0;
						if (tag_s1 == last_idx) begin
							done_q  <= 1'b1;
							iss_q   <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= tag_s1 + SW'(1);
							state_q <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (iss_q) begin
						if (idx_q == last_idx) begin
							iss_q <= 1'b0;
						end else begin
							idx_q <= idx_q + SW'(1);
						end
					end
					if (v1_s1 && (tag_s1 == last_idx)) begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					iss_q   <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign slot_out     = slot_out_q;
	assign window_count = 4'(used_q);

endmodule

@@ src/wzh_store.sv @@
// ----------------------------------------------------------------------------
// wzh_store
// rectangle table and stacking order memories, registered read ports
// ----------------------------------------------------------------------------
module wzh_store #(
	parameter int MAX_SLOTS = 8,
	localparam int SW = $clog2(MAX_SLOTS)
) (
	input  logic           clk,
	input  logic           rect_we,
	input  logic [SW-1:0]  rect_waddr,
	input  wzh_pkg::rect_t rect_wdata,
	input  logic [SW-1:0]  rect_raddr,
	output wzh_pkg::rect_t rect_rdata,
	input  logic           stack_we,
	input  logic [SW-1:0]  stack_waddr,
	input  logic [SW-1:0]  stack_wdata,
	input  logic [SW-1:0]  stack_raddr,
	output logic [SW-1:0]  stack_rdata
);
	import wzh_pkg::*;

	rect_t       rect_mem  [MAX_SLOTS];
	logic [SW-1:0] stack_mem [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (rect_we) begin
			rect_mem[rect_waddr] <= rect_wdata;
		end
		rect_rdata <= rect_mem[rect_raddr];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		stack_rdata <= stack_mem[stack_raddr];
	end

endmodule

@@ src/wzh_hit_unit.sv @@
// ----------------------------------------------------------------------------
// wzh_hit_unit
// half-open rectangle containment test for one point
// ----------------------------------------------------------------------------
module wzh_hit_unit (
	input  logic signed [10:0] px,
	input  logic signed [10:0] py,
	input  wzh_pkg::rect_t     rect,
	output logic               hit
);
	import wzh_pkg::*;

	logic signed [11:0] dx;
	logic signed [11:0] dy;
	logic               in_x;
	logic               in_y;

	// offset from the corner, must be non-negative and below the extent
	assign dx   = {px[10], px} - {rect.left[10], rect.left};
	assign dy   = {py[10], py} - {rect.top[10], rect.top};
	assign in_x = !dx[11] && (dx[10:0] < {1'b0, rect.width});
	assign in_y = !dy[11] && (dy[10:0] < {1'b0, rect.height});
	assign hit  = in_x && in_y;

endmodule

@@ test/wzh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wzh_checker
// watches the request and result ports of the window stacking order hit
// test, keeps its own window table and stack, and compares every result
// with the oldest outstanding prediction
// ----------------------------------------------------------------------------
module wzh_checker #(
	parameter int MAX_SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [10:0] pos_x,
	input  logic signed [10:0] pos_y,
	input  logic [9:0]         width,
	input  logic [9:0]         height,
	input  logic [2:0]         slot,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [2:0]         slot_out,
	input  logic [3:0]         window_count,
	output int                 outstanding,
	output int                 mismatches,
	output int                 checked
);
	import wzh_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] slot;
		logic [3:0] count;
	} answer_t;

	logic signed [10:0] win_left   [MAX_SLOTS];
	logic signed [10:0] win_top    [MAX_SLOTS];
	logic [9:0]         win_width  [MAX_SLOTS];
	logic [9:0]         win_height [MAX_SLOTS];
	logic [2:0]         z_stack    [MAX_SLOTS];
	int                 n_windows;

	answer_t expected_answers [$];
	int      err_cnt;
	int      chk_cnt;

	function automatic bit covers(logic [2:0] s, logic signed [10:0] px,
			logic signed [10:0] py);
		int l;
		int t;
		l = int'(win_left[s]);
		t = int'(win_top[s]);
		return int'(px) >= l && int'(px) < l + int'(win_width[s]) &&
			int'(py) >= t && int'(py) < t + int'(win_height[s]);
	endfunction

	function automatic answer_t apply_request(logic [1:0] op,
			logic signed [10:0] px, logic signed [10:0] py,
			logic [9:0] w, logic [9:0] h, logic [2:0] sel);
		answer_t a;
		bit      hit;
		int      pos;
		int      i;
		a.status = ST_OK;
		a.slot   = '0;
		case (op)
			OP_REG: begin
				if (n_windows >= MAX_SLOTS) begin
					a.status = ST_FULL;
				end else begin
					win_left[n_windows]   = px;
					win_top[n_windows]    = py;
					win_width[n_windows]  = w;
					win_height[n_windows] = h;
					z_stack[n_windows]    = 3'(n_windows);
					a.slot = 3'(n_windows);
					n_windows++;
				end
			end
			OP_HIT: begin
				a.status = ST_MISS;
				hit = 1'b0;
				for (i = n_windows - 1; i >= 0; i--) begin
					if (!hit && covers(z_stack[i], px, py)) begin
						hit = 1'b1;
						a.status = ST_OK;
						a.slot = z_stack[i];
					end
				end
			end
			OP_RAISE: begin
				if (int'(sel) >= n_windows) begin
					a.status = ST_UNREG;
				end else begin
					pos = n_windows;
					for (i = n_windows - 1; i >= 0; i--) begin
						if (z_stack[i] == sel) begin
							pos = i;
						end
					end
					if (pos + 1 < n_windows) begin
						for (i = pos; i + 1 < n_windows; i++) begin
							z_stack[i] = z_stack[i + 1];
						end
						z_stack[n_windows - 1] = sel;
					end
				end
			end
			default: begin
			end
		endcase
		a.count = 4'(n_windows);
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			expected_answers.delete();
			n_windows = 0;
			err_cnt = 0;
			chk_cnt = 0;
			outstanding <= 0;
			mismatches <= 0;
			checked <= 0;
		end else begin
			if (done) begin
				if (expected_answers.size() == 0) begin
					if (err_cnt < REPORT_LIMIT) begin
						$display("unexpected result: status %0d slot %0d count %0d",
							status, slot_out, window_count);
					end
					err_cnt++;
				end else begin
					want = expected_answers.pop_front();
					chk_cnt++;
					if (want.status !== status || want.slot !== slot_out ||
							want.count !== window_count) begin
						if (err_cnt < REPORT_LIMIT) begin
							$display("mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
								chk_cnt, want.status, want.slot, want.count,
								status, slot_out, window_count);
						end
						err_cnt++;
					end
				end
			end
			if (start && !busy) begin
				expected_answers.push_back(apply_request(operation, pos_x, pos_y,
					width, height, slot));
			end
			outstanding <= expected_answers.size();
			mismatches <= err_cnt;
			checked <= chk_cnt;
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives register, hit-test and bring-to-top requests into the window
// stacking order hit test: a directed pass over edges, empty rectangles,
// full table and bad slots, then random phases with varied idle gaps
// ----------------------------------------------------------------------------
module tb_top;
	import wzh_pkg::*;

	localparam int         MAX_SLOTS    = 8;
	localparam logic [1:0] OP_SPARE     = 2'd3;
	localparam int         PHASES       = 4;
	localparam int         PHASE_ITEMS  = 488;
	localparam int         TAIL_CYCLES  = 50;
	localparam int         CYCLE_LIMIT  = 600000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         operation = '0;
	logic signed [10:0] pos_x = '0;
	logic signed [10:0] pos_y = '0;
	logic [9:0]         width = '0;
	logic [9:0]         height = '0;
	logic [2:0]         slot = '0;
	wire                busy;
	wire                done;
	wire [1:0]          status;
	wire [2:0]          slot_out;
	wire [3:0]          window_count;
	int                 outstanding;
	int                 mismatches;
	int                 checked;

	int cycle_cnt = 0;
	int win_x [MAX_SLOTS];
	int win_y [MAX_SLOTS];
	int win_w [MAX_SLOTS];
	int win_h [MAX_SLOTS];
	int n_placed = 0;
	int n_reg = 0;
	int n_hit = 0;
	int n_raise = 0;
	int n_spare = 0;

	window_zorder_hit_test #(.MAX_SLOTS(MAX_SLOTS)) dut (.*);

	wzh_checker #(.MAX_SLOTS(MAX_SLOTS)) u_chk (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] op, logic signed [10:0] x,
			logic signed [10:0] y, logic [9:0] w, logic [9:0] h, logic [2:0] s);
		operation <= op;
		pos_x <= x;
		pos_y <= y;
		width <= w;
		height <= h;
		slot <= s;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		case (op)
			OP_REG: begin
				n_reg++;
				if (n_placed < MAX_SLOTS) begin
					win_x[n_placed] = int'(x);
					win_y[n_placed] = int'(y);
					win_w[n_placed] = int'(w);
					win_h[n_placed] = int'(h);
					n_placed++;
				end
			end
			OP_HIT:   n_hit++;
			OP_RAISE: n_raise++;
			default:  n_spare++;
		endcase
	endtask

	task automatic req_register(int x, int y, int w, int h);
		send_request(OP_REG, 11'(x), 11'(y), 10'(w), 10'(h), 3'($urandom));
	endtask

	task automatic req_hit(int x, int y);
		send_request(OP_HIT, 11'(x), 11'(y), 10'($urandom), 10'($urandom),
			3'($urandom));
	endtask

	task automatic req_raise(int s);
		send_request(OP_RAISE, 11'($urandom), 11'($urandom), 10'($urandom),
			10'($urandom), 3'(s));
	endtask

	task automatic req_spare();
		send_request(OP_SPARE, 11'($urandom), 11'($urandom), 10'($urandom),
			10'($urandom), 3'($urandom));
	endtask

	task automatic pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// wait until every request has its result
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic int pick_gap(int mode);
		int r;
		r = $urandom_range(99);
		if (mode == 1) return 0;
		if (mode == 2 && r < 30) return $urandom_range(4, 15);
		if (r < 60) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// offset near an edge of a span, or somewhere inside it
	function automatic int edge_offset(int span);
		case ($urandom_range(4))
			0:       return 0;
			1:       return span - 1;
			2:       return span;
			3:       return -1;
			default: return span > 0 ? int'($urandom_range(span - 1)) : 0;
		endcase
	endfunction

	task automatic random_request();
		int r;
		int k;
		r = $urandom_range(99);
		if (r < 45) begin
			if ($urandom_range(9) < 6 && n_placed > 0) begin
				k = $urandom_range(n_placed - 1);
				req_hit(win_x[k] + edge_offset(win_w[k]), win_y[k] + edge_offset(win_h[k]));
			end else begin
				req_hit(int'($urandom_range(2047)), int'($urandom_range(2047)));
			end
		end else if (r < 80) begin
			req_raise(int'($urandom_range(7)));
		end else if (r < 93) begin
			req_register(int'($urandom_range(2047)), int'($urandom_range(2047)),
				int'($urandom_range(1023)), int'($urandom_range(1023)));
		end else begin
			req_spare();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		req_hit(0, 0);
		pause(pick_gap(0));
		req_raise(0);
		req_spare();
		// extremes and half-open edges
		req_register(-1024, -1024, 1023, 1023);
		req_hit(-1024, -1024);
		req_hit(-2, -2);
		pause(pick_gap(0));
		req_hit(-1, -2);
		req_register(1023, 1023, 1023, 1023);
		req_hit(1023, 1023);
		// zero width and zero height never hit
		req_register(0, 0, 0, 1023);
		req_hit(0, 0);
		req_register(10, 10, 1023, 0);
		req_hit(10, 10);
		pause(pick_gap(0));
		// overlap and raising
		req_register(-100, -100, 300, 300);
		req_register(0, 0, 300, 300);
		req_hit(50, 50);
		req_raise(4);
		req_hit(50, 50);
		req_raise(4);
		req_raise(7);
		req_raise(0);
		req_spare();
		// fill the table then overflow it
		req_register(int'($urandom_range(2047)), int'($urandom_range(2047)),
			int'($urandom_range(1, 1023)), int'($urandom_range(1, 1023)));
		req_register(1023, -1024, 1, 1023);
		req_register(5, 5, 5, 5);
		req_hit(1023, -1024);
		req_raise(3);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				random_request();
				pause(pick_gap(p % 3));
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("sent %0d requests: %0d register, %0d hit-test, %0d raise, %0d spare code",
			n_reg + n_hit + n_raise + n_spare, n_reg, n_hit, n_raise, n_spare);
		$display("checked %0d results, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ window_zorder_hit_test.f @@
src/wzh_pkg.sv
src/wzh_store.sv
src/wzh_hit_unit.sv
src/window_zorder_hit_test.sv
test/wzh_checker.sv
test/tb_top.sv
